/* rtl/tqg_pkg.sv */
// Shared types and constants of the tiled quad generator.
// Used by tqg_div and tiled_quad_generator; depends on nothing.
`default_nettype none
package tqg_pkg;

	localparam int POS_FRAC_BITS = 8;
	localparam int UV_FRAC_BITS  = 16;
	localparam int PW  = 40;  // position work width
	localparam int DVW = 50;  // signed dividend width
	localparam int DSW = 32;  // divisor width
	localparam int AW  = 35;  // multiplier operand a
	localparam int BW  = 24;  // multiplier operand b

	localparam logic [2:0] REG_TILE_W   = 3'd0;
	localparam logic [2:0] REG_TILE_H   = 3'd1;
	localparam logic [2:0] REG_USE_CNT  = 3'd2;
	localparam logic [2:0] REG_WRAP     = 3'd3;
	localparam logic [2:0] REG_SRC_L    = 3'd4;
	localparam logic [2:0] REG_SRC_T    = 3'd5;
	localparam logic [2:0] REG_SRC_W    = 3'd6;
	localparam logic [2:0] REG_SRC_H    = 3'd7;

	typedef struct packed {
		logic signed [23:0] rect_x;
		logic signed [23:0] rect_y;
		logic [22:0]        rect_w;
		logic [22:0]        rect_h;
		logic signed [23:0] pan_x;
		logic signed [23:0] pan_y;
	} in_t;

	typedef struct packed {
		logic signed [23:0] quad_x0;
		logic signed [23:0] quad_y0;
		logic signed [23:0] quad_x1;
		logic signed [23:0] quad_y1;
		logic signed [23:0] tex_u0;
		logic signed [23:0] tex_v0;
		logic signed [23:0] tex_u1;
		logic signed [23:0] tex_v1;
		logic               last_quad;
		logic               tiles_truncated;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE, S_OP, S_MUL, S_DIV, S_WAIT, S_TILE, S_PACK, S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		ST_WCX, ST_WSX, ST_WCY, ST_WSY,
		ST_TW, ST_TH, ST_OX, ST_OY, ST_NX, ST_NY,
		ST_CL, ST_CR, ST_CT, ST_CB
	} step_t;

	function automatic logic signed [23:0] sat24(input logic signed [PW-1:0] v);
		logic signed [23:0] r;
		if (v > $signed(PW'(24'sh7FFFFF)))
			r = 24'sh7FFFFF;
		else if (v < -$signed(PW'(32'sh800000)))
			r = -24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/tqg_div.sv */
// Shared restoring divider, one quotient bit per cycle, floor semantics.
// Depends on tqg_pkg; instantiated by tiled_quad_generator.
`default_nettype none
module tqg_div import tqg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic signed [DVW-1:0] dividend,
	input  wire logic [DSW-1:0]        divisor,
	output logic                       done,
	output logic signed [DVW-1:0]      quot,
	output logic [DSW-1:0]             rem
);
	localparam int NB = DVW - 1;

	logic          busy_q, done_q, neg_q;
	logic [5:0]    cnt_q;
	logic [NB-1:0] mag_q;
	logic [DSW-1:0] rem_q, dvs_q;
	logic [DSW:0]  trial, diff;
	logic          ge;
	logic signed [DVW-1:0] absd, qm;
	logic          rz;

	always_comb begin
		trial = {rem_q, mag_q[NB-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
		absd  = dividend[DVW-1] ? -dividend : dividend;
		qm    = $signed({1'b0, mag_q});
		rz    = rem_q == '0;
		if (!neg_q)
			quot = qm;
		else if (rz)
			quot = -qm;
		else
			quot = ~qm;
		rem  = (neg_q && !rz) ? dvs_q - rem_q : rem_q;
		done = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(NB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVW-1];
			mag_q <= absd[NB-1:0];
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
			mag_q <= {mag_q[NB-2:0], ge};
		end
	end
endmodule
`default_nettype wire

/* rtl/tiled_quad_generator.sv */
// Top level: registers, step sequencer, shared multiplier and divider.
// Depends on tqg_pkg and tqg_div.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_ready  | in_data (in_t)
//  out     | output    | out_valid/out_ready| out_data (out_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A division step runs operand select, multiply, divider start, the divider
// iterations and the write; a step that is not needed is skipped in operand select.
// Wrap mode: 4 steps, at least 2 of them skipped in count mode, then pack, emit.
// Tile mode: 6 steps, 2 skipped unless in count mode, then per quad a load,
// 4 clip checks (a full step for each cut edge), pack and emit.
// in_ready is high only in idle; output stalls hold the quad. Reset: idle, default config.
`default_nettype none
module tiled_quad_generator import tqg_pkg::*; #(
	parameter int MAX_TILES_X = 8,
	parameter int MAX_TILES_Y = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [22:0] cfg_data
);
	localparam int CXW = $clog2(MAX_TILES_X + 1);
	localparam int CYW = $clog2(MAX_TILES_Y + 1);

	logic [22:0] tw_reg_q, th_reg_q;
	logic        cnt_mode_q, wrap_q;
	logic [16:0] src_l_q, src_t_q, src_w_q, src_h_q;

	in_t    in_q;
	state_t state_q, state_d;
	step_t  step_q, step_nxt;
	logic   chain_end;
	state_t end_state;

	logic [22:0] cntx_q, cnty_q;
	logic [15:0] stx_q, sty_q;
	logic [DSW-1:0] tw_q, th_q;
	logic signed [PW-1:0] ox_q, oy_q, xc_q, yc_q;
	logic signed [PW-1:0] qx0_q, qx1_q, qy0_q, qy1_q;
	logic signed [23:0] u0_q, u1_q, v0_q, v1_q;
	logic [CXW-1:0] cx_q, i_q;
	logic [CYW-1:0] cy_q, j_q;
	logic trx_q, try_q;

	logic signed [AW-1:0]  opa, opa_q;
	logic signed [BW-1:0]  opb, opb_q;
	logic [DSW-1:0]        opd, dvs_q;
	logic signed [DVW-1:0] prod_q;
	logic                  skip;

	logic                  div_start, div_done;
	logic signed [DVW-1:0] div_q;
	logic [DSW-1:0]        div_r;

	logic signed [PW-1:0] rx, ry, rw, rh, sx, sy, rxe, rye;
	logic signed [PW-1:0] d_l, d_r, d_t, d_b;
	logic [DSW-1:0] twr, thr;
	logic [22:0] cnt_dx, cnt_dy;
	logic is_last;
	out_t pack;
	out_t out_q;

	tqg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dvs_q),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	always_comb begin
		rx  = PW'(in_q.rect_x);
		ry  = PW'(in_q.rect_y);
		rw  = $signed(PW'(in_q.rect_w));
		rh  = $signed(PW'(in_q.rect_h));
		sx  = PW'(in_q.pan_x);
		sy  = PW'(in_q.pan_y);
		rxe = rx + rw;
		rye = ry + rh;
		d_l = rx - qx0_q;
		d_r = qx1_q - rxe;
		d_t = ry - qy0_q;
		d_b = qy1_q - rye;
		twr = (tw_reg_q == '0) ? DSW'(1) : DSW'(tw_reg_q);
		thr = (th_reg_q == '0) ? DSW'(1) : DSW'(th_reg_q);
		cnt_dx = (twr > DSW'(32'h7FFF)) ? 23'h7FFFFF : {twr[14:0], 8'h00};
		cnt_dy = (thr > DSW'(32'h7FFF)) ? 23'h7FFFFF : {thr[14:0], 8'h00};
		is_last = (i_q == cx_q - CXW'(1)) && (j_q == cy_q - CYW'(1));
	end

	// operand select and skip decision for the current step
	always_comb begin
		opa  = '0;
		opb  = BW'(1);
		opd  = DSW'(1);
		skip = 1'b0;
		unique case (step_q)
			ST_WCX: begin
				skip = cnt_mode_q;
				opa = AW'(rw); opb = BW'(1 << UV_FRAC_BITS); opd = twr;
			end
			ST_WCY: begin
				skip = cnt_mode_q;
				opa = AW'(rh); opb = BW'(1 << UV_FRAC_BITS); opd = thr;
			end
			ST_WSX: begin
				opa = -AW'(sx);
				if (cnt_mode_q) begin
					skip = in_q.rect_w == '0;
					opb = $signed(BW'(cntx_q)); opd = DSW'(in_q.rect_w);
				end else begin
					opb = BW'(1 << UV_FRAC_BITS); opd = twr;
				end
			end
			ST_WSY: begin
				opa = -AW'(sy);
				if (cnt_mode_q) begin
					skip = in_q.rect_h == '0;
					opb = $signed(BW'(cnty_q)); opd = DSW'(in_q.rect_h);
				end else begin
					opb = BW'(1 << UV_FRAC_BITS); opd = thr;
				end
			end
			ST_TW: begin
				skip = !cnt_mode_q;
				opa = AW'(rw); opb = BW'(1 << POS_FRAC_BITS); opd = twr;
			end
			ST_TH: begin
				skip = !cnt_mode_q;
				opa = AW'(rh); opb = BW'(1 << POS_FRAC_BITS); opd = thr;
			end
			ST_OX: begin opa = AW'(sx); opd = tw_q; end
			ST_OY: begin opa = AW'(sy); opd = th_q; end
			ST_NX: begin
				opa = AW'(rw - ox_q + $signed(PW'(tw_q)) - PW'(1)); opd = tw_q;
			end
			ST_NY: begin
				opa = AW'(rh - oy_q + $signed(PW'(th_q)) - PW'(1)); opd = th_q;
			end
			ST_CL: begin
				skip = d_l <= 0;
				opa = AW'(d_l); opb = $signed(BW'(src_w_q)); opd = tw_q;
			end
			ST_CR: begin
				skip = d_r <= 0;
				opa = AW'(d_r); opb = $signed(BW'(src_w_q)); opd = tw_q;
			end
			ST_CT: begin
				skip = d_t <= 0;
				opa = AW'(d_t); opb = $signed(BW'(src_h_q)); opd = th_q;
			end
			ST_CB: begin
				skip = d_b <= 0;
				opa = AW'(d_b); opb = $signed(BW'(src_h_q)); opd = th_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		step_nxt  = step_q;
		chain_end = 1'b0;
		end_state = S_PACK;
		unique case (step_q)
			ST_WCX: step_nxt = ST_WSX;
			ST_WSX: step_nxt = ST_WCY;
			ST_WCY: step_nxt = ST_WSY;
			ST_WSY: chain_end = 1'b1;
			ST_TW:  step_nxt = ST_TH;
			ST_TH:  step_nxt = ST_OX;
			ST_OX:  step_nxt = ST_OY;
			ST_OY:  step_nxt = ST_NX;
			ST_NX:  step_nxt = ST_NY;
			ST_NY:  begin chain_end = 1'b1; end_state = S_TILE; end
			ST_CL:  step_nxt = ST_CR;
			ST_CR:  step_nxt = ST_CT;
			ST_CT:  step_nxt = ST_CB;
			ST_CB:  chain_end = 1'b1;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_OP;
			S_OP: begin
				if (!skip)
					state_d = S_MUL;
				else if (chain_end)
					state_d = end_state;
			end
			S_MUL:  state_d = S_DIV;
			S_DIV:  state_d = S_WAIT;
			S_WAIT: if (div_done) state_d = chain_end ? end_state : S_OP;
			S_TILE: state_d = S_OP;
			S_PACK: state_d = S_EMIT;
			S_EMIT: if (out_ready) state_d = out_data.last_quad ? S_IDLE : S_TILE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = state_q == S_IDLE;
		out_valid = state_q == S_EMIT;
		div_start = state_q == S_DIV;
		cfg_ready = 1'b1;
		out_data  = out_q;
	end

	always_comb begin
		if (wrap_q) begin
			pack.quad_x0 = sat24(rx);
			pack.quad_y0 = sat24(ry);
			pack.quad_x1 = sat24(rxe);
			pack.quad_y1 = sat24(rye);
			pack.tex_u0  = $signed(24'(stx_q));
			pack.tex_v0  = $signed(24'(sty_q));
			pack.tex_u1  = sat24($signed(PW'(stx_q)) + $signed(PW'(cntx_q)));
			pack.tex_v1  = sat24($signed(PW'(sty_q)) + $signed(PW'(cnty_q)));
			pack.last_quad = 1'b1;
			pack.tiles_truncated = 1'b0;
		end else begin
			pack.quad_x0 = sat24(qx0_q);
			pack.quad_y0 = sat24(qy0_q);
			pack.quad_x1 = sat24(qx1_q);
			pack.quad_y1 = sat24(qy1_q);
			pack.tex_u0  = u0_q;
			pack.tex_v0  = v0_q;
			pack.tex_u1  = u1_q;
			pack.tex_v1  = v1_q;
			pack.last_quad = is_last;
			pack.tiles_truncated = trx_q | try_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_reg_q   <= 23'd4096;
			th_reg_q   <= 23'd4096;
			cnt_mode_q <= 1'b0;
			wrap_q     <= 1'b0;
			src_l_q    <= '0;
			src_t_q    <= '0;
			src_w_q    <= 17'd65536;
			src_h_q    <= 17'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TILE_W:  tw_reg_q   <= cfg_data;
				REG_TILE_H:  th_reg_q   <= cfg_data;
				REG_USE_CNT: cnt_mode_q <= cfg_data[0];
				REG_WRAP:    wrap_q     <= cfg_data[0];
				REG_SRC_L:   src_l_q    <= cfg_data[16:0];
				REG_SRC_T:   src_t_q    <= cfg_data[16:0];
				REG_SRC_W:   src_w_q    <= cfg_data[16:0];
				REG_SRC_H:   src_h_q    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_WCX;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid)
				step_q <= wrap_q ? ST_WCX : ST_TW;
			else if (state_q == S_TILE)
				step_q <= ST_CL;
			else if ((state_q == S_OP && skip) || (state_q == S_WAIT && div_done))
				step_q <= step_nxt;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			in_q <= in_data;
		if (state_q == S_OP) begin
			opa_q <= opa;
			opb_q <= opb;
			dvs_q <= opd;
		end
		if (state_q == S_MUL)
			prod_q <= DVW'(opa_q * opb_q);
		if (state_q == S_PACK)
			out_q <= pack;

		if (state_q == S_OP && skip) begin
			unique case (step_q)
				ST_WCX: cntx_q <= cnt_dx;
				ST_WCY: cnty_q <= cnt_dy;
				ST_WSX: stx_q  <= '0;
				ST_WSY: sty_q  <= '0;
				ST_TW:  tw_q   <= twr;
				ST_TH:  th_q   <= thr;
				default: ;
			endcase
		end

		if (state_q == S_WAIT && div_done) begin
			unique case (step_q)
				ST_WCX: cntx_q <= (div_q > DVW'(24'h7FFFFF)) ? 23'h7FFFFF : div_q[22:0];
				ST_WCY: cnty_q <= (div_q > DVW'(24'h7FFFFF)) ? 23'h7FFFFF : div_q[22:0];
				ST_WSX: stx_q <= div_q[15:0];
				ST_WSY: sty_q <= div_q[15:0];
				ST_TW:  tw_q <= (div_q < DVW'(1)) ? DSW'(1) : div_q[DSW-1:0];
				ST_TH:  th_q <= (div_q < DVW'(1)) ? DSW'(1) : div_q[DSW-1:0];
				ST_OX:  ox_q <= $signed(PW'(div_r)) - $signed(PW'(tw_q));
				ST_OY:  oy_q <= $signed(PW'(div_r)) - $signed(PW'(th_q));
				ST_NX: begin
					trx_q <= div_q > DVW'(MAX_TILES_X);
					cx_q  <= (div_q > DVW'(MAX_TILES_X)) ? CXW'(MAX_TILES_X)
						: div_q[CXW-1:0];
				end
				ST_NY: begin
					try_q <= div_q > DVW'(MAX_TILES_Y);
					cy_q  <= (div_q > DVW'(MAX_TILES_Y)) ? CYW'(MAX_TILES_Y)
						: div_q[CYW-1:0];
					i_q  <= '0;
					j_q  <= '0;
					xc_q <= rx + ox_q;
					yc_q <= ry + oy_q;
				end
				ST_CL: begin u0_q <= u0_q + div_q[23:0]; qx0_q <= rx;  end
				ST_CR: begin u1_q <= u1_q - div_q[23:0]; qx1_q <= rxe; end
				ST_CT: begin v0_q <= v0_q + div_q[23:0]; qy0_q <= ry;  end
				ST_CB: begin v1_q <= v1_q - div_q[23:0]; qy1_q <= rye; end
				default: ;
			endcase
		end

		// load the unclipped tile
		if (state_q == S_TILE) begin
			qx0_q <= xc_q;
			qx1_q <= xc_q + $signed(PW'(tw_q));
			qy0_q <= yc_q;
			qy1_q <= yc_q + $signed(PW'(th_q));
			u0_q  <= $signed(24'(src_l_q));
			u1_q  <= $signed(24'(src_l_q)) + $signed(24'(src_w_q));
			v0_q  <= $signed(24'(src_t_q));
			v1_q  <= $signed(24'(src_t_q)) + $signed(24'(src_h_q));
		end

		// advance to the next tile after a transfer
		if (state_q == S_EMIT && out_ready && !out_data.last_quad) begin
			if (i_q == cx_q - CXW'(1)) begin
				i_q  <= '0;
				j_q  <= j_q + CYW'(1);
				xc_q <= rx + ox_q;
				yc_q <= yc_q + $signed(PW'(th_q));
			end else begin
				i_q  <= i_q + CXW'(1);
				xc_q <= xc_q + $signed(PW'(tw_q));
			end
		end
	end
endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench of tiled_quad_generator: walks the block through several register
// settings, predicts every quad in a scoreboard class and checks each output.
// Depends on tqg_pkg and the RTL of tiled_quad_generator.
`timescale 1ns / 1ps
module tb import tqg_pkg::*; ();

	class quad_scoreboard;
		longint tile_w_reg, tile_h_reg, count_mode, wrap_mode;
		longint src_l, src_t, src_w, src_h;
		out_t   quads_due[$];
		int     fails;

		function new();
			tile_w_reg = 4096; tile_h_reg = 4096; count_mode = 0; wrap_mode = 0;
			src_l = 0; src_t = 0; src_w = 65536; src_h = 65536; fails = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [22:0] val);
			case (idx)
				REG_TILE_W:  tile_w_reg = val;
				REG_TILE_H:  tile_h_reg = val;
				REG_USE_CNT: count_mode = val[0];
				REG_WRAP:    wrap_mode  = val[0];
				REG_SRC_L:   src_l = val[16:0];
				REG_SRC_T:   src_t = val[16:0];
				REG_SRC_W:   src_w = val[16:0];
				REG_SRC_H:   src_h = val[16:0];
				default: ;
			endcase
		endfunction

		function longint floor_div(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0)
				q--;
			return q;
		endfunction

		function logic signed [23:0] clamp24(longint v);
			if (v > 64'sh7FFFFF)
				return 24'sh7FFFFF;
			if (v < -64'sh800000)
				return -24'sh800000;
			return v[23:0];
		endfunction

		function void wrap_span(longint size, longint treg, longint scroll,
				output longint c0, output longint c1);
			longint cnt, start;
			if (count_mode != 0) begin
				cnt = treg * 256;
				if (cnt > 64'h7FFFFF)
					cnt = 64'h7FFFFF;
				start = (size > 0) ? floor_div(-scroll * cnt, size) : 0;
			end else begin
				cnt = floor_div(size * 65536, treg);
				if (cnt > 64'h7FFFFF)
					cnt = 64'h7FFFFF;
				start = floor_div(-scroll * 65536, treg);
			end
			start &= 65535;
			c0 = start;
			c1 = start + cnt;
		endfunction

		function longint tile_extent(longint size, longint treg);
			longint t;
			t = treg;
			if (count_mode != 0)
				t = floor_div(size * 256, treg);
			return (t < 1) ? 1 : t;
		endfunction

		function void push_quad(longint x0, longint y0, longint x1, longint y1,
				longint u0, longint v0, longint u1, longint v1, bit last, bit trunc);
			out_t q;
			q.quad_x0 = clamp24(x0); q.quad_y0 = clamp24(y0);
			q.quad_x1 = clamp24(x1); q.quad_y1 = clamp24(y1);
			q.tex_u0 = clamp24(u0); q.tex_v0 = clamp24(v0);
			q.tex_u1 = clamp24(u1); q.tex_v1 = clamp24(v1);
			q.last_quad = last;
			q.tiles_truncated = trunc;
			quads_due.push_back(q);
		endfunction

		// Expand one accepted rectangle into the quads it must produce.
		function void note_rect(in_t r);
			longint rx, ry, rw, rh, sx, sy, twr, thr, tw, th, ox, oy, nx, ny;
			longint u0, u1, v0, v1, x0, x1, y0, y1, d;
			int cx, cy;
			bit trunc;
			rx = r.rect_x; ry = r.rect_y; rw = r.rect_w; rh = r.rect_h;
			sx = r.pan_x; sy = r.pan_y;
			twr = (tile_w_reg != 0) ? tile_w_reg : 1;
			thr = (tile_h_reg != 0) ? tile_h_reg : 1;
			if (wrap_mode != 0) begin
				wrap_span(rw, twr, sx, u0, u1);
				wrap_span(rh, thr, sy, v0, v1);
				push_quad(rx, ry, rx + rw, ry + rh, u0, v0, u1, v1, 1, 0);
				return;
			end
			tw = tile_extent(rw, twr);
			th = tile_extent(rh, thr);
			ox = sx - floor_div(sx, tw) * tw - tw;
			oy = sy - floor_div(sy, th) * th - th;
			nx = (rw - ox + tw - 1) / tw;
			ny = (rh - oy + th - 1) / th;
			trunc = (nx > 8 || ny > 8);
			cx = (nx > 8) ? 8 : int'(nx);
			cy = (ny > 8) ? 8 : int'(ny);
			for (int j = 0; j < cy; j++) begin
				for (int i = 0; i < cx; i++) begin
					x0 = rx + ox + i * tw; x1 = x0 + tw;
					y0 = ry + oy + j * th; y1 = y0 + th;
					u0 = src_l; u1 = src_l + src_w; v0 = src_t; v1 = src_t + src_h;
					d = rx - x0;
					if (d > 0) begin
						u0 += floor_div(d * src_w, tw); x0 += d;
					end
					d = x1 - (rx + rw);
					if (d > 0) begin
						u1 -= floor_div(d * src_w, tw); x1 -= d;
					end
					d = ry - y0;
					if (d > 0) begin
						v0 += floor_div(d * src_h, th); y0 += d;
					end
					d = y1 - (ry + rh);
					if (d > 0) begin
						v1 -= floor_div(d * src_h, th); y1 -= d;
					end
					push_quad(x0, y0, x1, y1, u0, v0, u1, v1,
						(i == cx - 1 && j == cy - 1), trunc);
				end
			end
		endfunction

		function void cmp_field(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				fails++;
			end
		endfunction

		function void check_quad(out_t a);
			out_t e;
			if (quads_due.size() == 0) begin
				$error("quad with nothing expected: %h", a);
				fails++;
				return;
			end
			e = quads_due.pop_front();
			cmp_field("quad_x0", e.quad_x0, a.quad_x0);
			cmp_field("quad_y0", e.quad_y0, a.quad_y0);
			cmp_field("quad_x1", e.quad_x1, a.quad_x1);
			cmp_field("quad_y1", e.quad_y1, a.quad_y1);
			cmp_field("tex_u0", e.tex_u0, a.tex_u0);
			cmp_field("tex_v0", e.tex_v0, a.tex_v0);
			cmp_field("tex_u1", e.tex_u1, a.tex_u1);
			cmp_field("tex_v1", e.tex_v1, a.tex_v1);
			cmp_field("last_quad", e.last_quad, a.last_quad);
			cmp_field("tiles_truncated", e.tiles_truncated, a.tiles_truncated);
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_t         in_data;
	out_t        out_data;
	logic [2:0]  cfg_index;
	logic [22:0] cfg_data;

	quad_scoreboard sb;
	int  burst_left;
	int  stall_pct;
	bit  long_hold;
	longint cur_tw, cur_th;
	bit  cur_count;

	tiled_quad_generator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("[tiled_quad_generator] ERROR");
		$finish;
	end

	// Receiver: random stall density, plus one long hold on request.
	initial begin
		int hold_cnt;
		int tick;
		hold_cnt = 0;
		tick = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_quad(out_data);
			if (long_hold && hold_cnt == 0)
				hold_cnt = 3000;
			tick++;
			if (tick % 200 == 0)
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 30;
					2: stall_pct = 70;
					default: stall_pct = 90;
				endcase
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0)
					long_hold = 0;
				out_ready <= 0;
			end else
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(logic [2:0] idx, logic [22:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic drain();
		while (sb.quads_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_setting(logic [22:0] tw, logic [22:0] th, bit cnt, bit wrp,
			logic [22:0] sl, logic [22:0] st, logic [22:0] sw, logic [22:0] sh);
		drain();
		write_reg(REG_TILE_W, tw);
		write_reg(REG_TILE_H, th);
		write_reg(REG_USE_CNT, cnt);
		write_reg(REG_WRAP, wrp);
		write_reg(REG_SRC_L, sl);
		write_reg(REG_SRC_T, st);
		write_reg(REG_SRC_W, sw);
		write_reg(REG_SRC_H, sh);
		cfg_valid <= 0;
		cur_tw = (tw == 0) ? 1 : tw;
		cur_th = (th == 0) ? 1 : th;
		cur_count = cnt;
		@(posedge clk);
	endtask

	// Sender: bursts of random length; valid stays high inside a burst.
	task automatic send_rect(in_t r);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_rect(r);
		burst_left--;
	endtask

	function automatic in_t pick_rect();
		in_t r;
		longint lim_w, lim_h;
		r.rect_x = 24'($urandom);
		r.rect_y = 24'($urandom);
		r.rect_w = 23'($urandom);
		r.rect_h = 23'($urandom);
		r.pan_x = 24'($urandom);
		r.pan_y = 24'($urandom);
		if ($urandom_range(0, 9) != 0) begin
			// mostly a few tiles per axis to keep the grid small
			lim_w = cur_count ? 64'd40000 : 3 * cur_tw;
			lim_h = cur_count ? 64'd40000 : 3 * cur_th;
			if (lim_w > 64'h7FFFFF) lim_w = 64'h7FFFFF;
			if (lim_h > 64'h7FFFFF) lim_h = 64'h7FFFFF;
			r.rect_w = 23'($urandom_range(0, int'(lim_w)));
			r.rect_h = 23'($urandom_range(0, int'(lim_h)));
			if ($urandom_range(0, 1)) begin
				r.pan_x = 24'($signed($urandom_range(0, 20000)) - 10000);
				r.pan_y = 24'($signed($urandom_range(0, 20000)) - 10000);
			end
		end
		return r;
	endfunction

	task automatic corner_rects();
		in_t r;
		r = '{24'sh7FFFFF, -24'sh800000, 23'h7FFFFF, 23'h7FFFFF, 24'sh7FFFFF, -24'sh800000};
		send_rect(r);
		r = '{-24'sh800000, 24'sh7FFFFF, 23'd0, 23'd0, -24'sh800000, 24'sh7FFFFF};
		send_rect(r);
		r = '{24'sd0, 24'sd0, 23'd0, 23'd5000, 24'sd0, 24'sd0};
		send_rect(r);
		r = '{24'sd100, -24'sd100, 23'd9000, 23'd0, -24'sd1, 24'sd1};
		send_rect(r);
	endtask

	task automatic run_phase(int n);
		corner_rects();
		for (int k = 0; k < n; k++)
			send_rect(pick_rect());
	endtask

	initial begin
		sb = new();
		burst_left = 0;
		stall_pct = 0;
		long_hold = 0;
		cur_tw = 4096; cur_th = 4096; cur_count = 0;
		arst_n = 0;
		in_valid = 0; in_data = '0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset setting first, then receiver held off while the sender keeps offering
		run_phase(20);
		long_hold = 1;
		run_phase(20);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'd1, 23'h7FFFFF, 0, 0, 23'd65536, 23'd0, 23'd1, 23'd65536);
		run_phase(12);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'd0, 23'd3000, 0, 0, 23'd12345, 23'd40000, 23'd30000, 23'd1);
		run_phase(55);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'd2000, 23'd2500, 0, 1, 23'd0, 23'd0, 23'd65536, 23'd65536);
		run_phase(55);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'd512, 23'd768, 1, 1, 23'd100, 23'd200, 23'd300, 23'd400);
		run_phase(55);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'h7FFFFF, 23'd0, 1, 1, 23'd0, 23'd65536, 23'd65536, 23'd1);
		run_phase(55);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'd768, 23'd512, 1, 0, 23'd1000, 23'd2000, 23'd50000, 23'd60000);
		run_phase(60);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'h7FFFFF, 23'd1, 1, 0, 23'd7, 23'd9, 23'd65536, 23'd65536);
		run_phase(10);
		in_valid <= 0;
		burst_left = 0;
		load_setting(23'd4096, 23'd4096, 0, 0, 23'd0, 23'd0, 23'd65536, 23'd65536);
		run_phase(60);
		in_valid <= 0;
		drain();

		if (sb.fails == 0 && sb.quads_due.size() == 0)
			$display("[tiled_quad_generator] OK");
		else
			$display("[tiled_quad_generator] ERROR");
		$finish;
	end
endmodule

/* files.f */
rtl/tqg_pkg.sv
rtl/tqg_div.sv
rtl/tiled_quad_generator.sv
test/tb.sv
